### rtl/appc_pkg.sv
// Package for the ATA pass-through policy check.
// Holds beat layouts, opcode and command bytes, sense codes and the verdict type.
// No dependencies.
package appc_pkg;

   // Beat widths: request 169 bits of fields padded to 176, response 79 padded to 80
   localparam int REQ_W = 176;
   localparam int RSP_W = 80;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SECTORS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MOUNTED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LBA_MODE      = 2'd2;

   localparam logic [7:0] MAX_SECTORS_RST = 8'd128;
   localparam int         SECTOR_BYTES_DEF = 512;

   // CDB opcodes and ATA command bytes
   localparam logic [7:0] OPC_SAT12    = 8'hA1;
   localparam logic [7:0] OPC_SAT16    = 8'h85;
   localparam logic [7:0] LEN_SAT12    = 8'd12;
   localparam logic [7:0] LEN_SAT16    = 8'd16;
   localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
   localparam logic [7:0] CMD_READ     = 8'h20;
   localparam logic [7:0] CMD_READ_NR  = 8'h21;
   localparam logic [7:0] CMD_READ_EXT = 8'h24;
   localparam logic [7:0] BYTE2_PIO_IN = 8'h0E;
   localparam logic [3:0] PROTO_PIO_IN = 4'd4;
   localparam logic [7:0] DEV_LBA      = 8'h40;
   localparam logic [7:0] DEV_EXT_MASK = 8'h4F;

   // Sense key and additional code
   localparam logic [1:0] SK_NONE      = 2'd0;
   localparam logic [1:0] SK_ILLEGAL   = 2'd1;
   localparam logic [1:0] SK_NOT_READY = 2'd2;
   localparam logic [2:0] SC_NONE       = 3'd0;
   localparam logic [2:0] SC_BAD_OPCODE = 3'd1;
   localparam logic [2:0] SC_BAD_FIELD  = 3'd2;
   localparam logic [2:0] SC_LBA_RANGE  = 3'd3;
   localparam logic [2:0] SC_NOT_READY  = 3'd4;

   typedef enum logic [2:0] {
      VERDICT_OK,
      VERDICT_BAD_OPCODE,
      VERDICT_BAD_FIELD,
      VERDICT_LBA_RANGE,
      VERDICT_NOT_READY
   } verdict_type;

endpackage

### rtl/ata_passthrough_policy_check_top.sv
// ATA pass-through policy check, top level.
// Depends on appc_pkg for beat layouts, command bytes and sense codes.
// One module: decode stage, check stage, output register.

// Judges one ATA PASS-THROUGH CDB per beat and answers with either an allowed
// task file or a refusal (sense key and code, task file zeroed). The block takes
// a new beat every cycle unless an rsp_ beat is held; each beat's answer passes
// through the decode register (loaded at the accepting edge), the check register
// and the output register before it appears on the rsp_ side. A held rsp_ beat
// freezes the whole pipeline and deasserts req_tready, so no beat is dropped or
// duplicated. The user writes configuration through csr_ only while the block is
// idle, which the block does not enforce; it takes effect on the next beat.
module ata_passthrough_policy_check_top #(
   parameter int SECTOR_BYTES = appc_pkg::SECTOR_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // cdb_head[63:0], cdb_tail[127:64], cdb_length[135:128], data_in[136],
   // transfer_bytes[168:137], zero pad above
   input  logic [appc_pkg::REQ_W-1:0]       req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // allowed[0], sense_key[2:1], sense_code[5:3], ata_command[13:6],
   // ata_device[21:14], sector_count[29:22], task_lba[77:30], extended[78], pad[79]
   output logic [appc_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wen,
   input  logic [appc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [appc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import appc_pkg::*;

   localparam int PROD_W = 8 + $clog2(SECTOR_BYTES);

   // ---------------- configuration registers
   logic [7:0] max_sectors_ff, max_sectors_in;
   logic       mounted_ff, mounted_in;
   logic       lba_mode_ff, lba_mode_in;

   always_comb begin
      max_sectors_in = max_sectors_ff;
      mounted_in     = mounted_ff;
      lba_mode_in    = lba_mode_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_MAX_SECTORS:   max_sectors_in = csr_wdata;
            CSR_DRIVE_MOUNTED: mounted_in     = csr_wdata[0];
            CSR_LBA_MODE:      lba_mode_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_sectors_ff <= MAX_SECTORS_RST;
         mounted_ff     <= 1'b0;
         lba_mode_ff    <= 1'b0;
      end else begin
         max_sectors_ff <= max_sectors_in;
         mounted_ff     <= mounted_in;
         lba_mode_ff    <= lba_mode_in;
      end
   end

   // ---------------- pipeline advance: whole pipe moves unless the output is held
   logic advance;
   logic rsp_tvalid_ff;
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------- stage 1: decode CDB bytes by form
   logic [7:0]  c [16];
   logic [7:0]  cdb_len;
   logic        dir_in;
   logic [31:0] xfer_bytes;

   logic        s1_valid_ff;
   logic        form_ok_ff, form_ok_in;
   logic        gen_bad_ff, gen_bad_in;
   logic        is16_ff, is16_in;
   logic        ext_ff, ext_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  dev_ff, dev_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  hcount_ff, hcount_in;
   logic [47:0] lba_ff, lba_in;       // {l5,l4,l3,l2,l1,l0}
   logic        dir_ff;
   logic [31:0] xfer_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      logic [7:0] b1, feat, hfeat, ctrl;
      logic       res12_bad;
      for (int k = 0; k < 8; k++) begin
         c[k]     = req_tdata[8*k +: 8];
         c[8 + k] = req_tdata[64 + 8*k +: 8];
      end
      cdb_len    = req_tdata[135:128];
      dir_in     = req_tdata[136];
      xfer_bytes = req_tdata[168:137];

      b1   = c[1];
      is16_in    = (c[0] == OPC_SAT16) && (cdb_len == LEN_SAT16);
      form_ok_in = ((c[0] == OPC_SAT12) && (cdb_len == LEN_SAT12)) || is16_in;

      if (is16_in) begin
         ext_in    = b1[0];
         hfeat     = c[3];
         feat      = c[4];
         hcount_in = c[5];
         count_in  = c[6];
         lba_in    = {c[11], c[9], c[7], c[12], c[10], c[8]};
         dev_in    = c[13];
         cmd_in    = c[14];
         ctrl      = c[15];
         res12_bad = 1'b0;
      end else begin
         ext_in    = 1'b0;
         hfeat     = 8'h00;
         feat      = c[3];
         hcount_in = 8'h00;
         count_in  = c[4];
         lba_in    = {24'h0, c[7], c[6], c[5]};
         dev_in    = c[8];
         cmd_in    = c[9];
         ctrl      = c[11];
         res12_bad = b1[0] || (c[10] != 8'h00);
      end

      // reserved bits, protocol, byte 2, control, features, device bit 4
      gen_bad_in = res12_bad || (b1[7:5] != 3'b000) || (b1[4:1] != PROTO_PIO_IN) ||
                   (c[2] != BYTE2_PIO_IN) || (ctrl != 8'h00) || (feat != 8'h00) ||
                   (hfeat != 8'h00) || dev_in[4];

      prod_in = PROD_W'(count_in) * PROD_W'(SECTOR_BYTES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         form_ok_ff <= form_ok_in;
         gen_bad_ff <= gen_bad_in;
         is16_ff    <= is16_in;
         ext_ff     <= ext_in;
         cmd_ff     <= cmd_in;
         dev_ff     <= dev_in;
         count_ff   <= count_in;
         hcount_ff  <= hcount_in;
         lba_ff     <= lba_in;
         dir_ff     <= dir_in;
         xfer_ff    <= xfer_bytes;
         prod_ff    <= prod_in;
      end
   end

   // ---------------- stage 2: command checks, range add, transfer compare, verdict
   logic        s2_valid_ff;
   verdict_type verdict_ff, verdict_in;
   logic [7:0]  s2_cmd_ff, s2_count_ff;
   logic [7:0]  tdev_ff, tdev_in;
   logic [47:0] s2_lba_ff;
   logic        s2_ext_ff;

   always_comb begin
      logic        cmd_bad, range_bad, is_identify, count_bad;
      logic [28:0] sum28;
      logic [48:0] sum48;
      cmd_bad     = 1'b0;
      range_bad   = 1'b0;
      is_identify = 1'b0;
      tdev_in     = 8'h00;
      count_bad   = (count_ff == 8'h00) || (count_ff > max_sectors_ff);
      sum28 = {1'b0, dev_ff[3:0], lba_ff[23:0]} + {21'h0, count_ff};
      sum48 = {1'b0, lba_ff} + {41'h0, count_ff};

      case (cmd_ff)
         CMD_IDENTIFY: begin
            is_identify = 1'b1;
            cmd_bad = ext_ff || (count_ff != 8'd1) || (hcount_ff != 8'h00) ||
                      (lba_ff != 48'h0) || (dev_ff[3:0] != 4'h0);
         end
         CMD_READ, CMD_READ_NR: begin
            cmd_bad = ext_ff || (hcount_ff != 8'h00) || (lba_ff[47:24] != 24'h0) ||
                      !dev_ff[6] || count_bad;
            range_bad = sum28 > 29'h1000_0000;
            tdev_in   = DEV_LBA | {4'h0, dev_ff[3:0]};
         end
         CMD_READ_EXT: begin
            cmd_bad = !is16_ff || !ext_ff || (hcount_ff != 8'h00) ||
                      ((dev_ff & DEV_EXT_MASK) != DEV_LBA) || count_bad;
            range_bad = sum48 > {1'b1, 48'h0};
            tdev_in   = DEV_LBA;
         end
         default: cmd_bad = 1'b1;
      endcase

      // priority follows the order the checks are defined in
      if (!form_ok_ff)
         verdict_in = VERDICT_BAD_OPCODE;
      else if (gen_bad_ff || cmd_bad)
         verdict_in = VERDICT_BAD_FIELD;
      else if (range_bad)
         verdict_in = VERDICT_LBA_RANGE;
      else if (!dir_ff || (xfer_ff != {{(32-PROD_W){1'b0}}, prod_ff}))
         verdict_in = VERDICT_BAD_FIELD;
      else if (!mounted_ff)
         verdict_in = VERDICT_NOT_READY;
      else if (!is_identify && !lba_mode_ff)
         verdict_in = VERDICT_BAD_FIELD;
      else
         verdict_in = VERDICT_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_ff  <= verdict_in;
         s2_cmd_ff   <= cmd_ff;
         s2_count_ff <= count_ff;
         tdev_ff     <= tdev_in;
         s2_lba_ff   <= lba_ff;
         s2_ext_ff   <= ext_ff;
      end
   end

   // ---------------- stage 3: format the response beat
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   always_comb begin
      logic        ok;
      logic [1:0]  key;
      logic [2:0]  code;
      logic [47:0] tlba;
      ok = 1'b0;
      case (verdict_ff)
         VERDICT_OK: begin
            ok = 1'b1; key = SK_NONE; code = SC_NONE;
         end
         VERDICT_BAD_OPCODE: begin
            key = SK_ILLEGAL; code = SC_BAD_OPCODE;
         end
         VERDICT_LBA_RANGE: begin
            key = SK_ILLEGAL; code = SC_LBA_RANGE;
         end
         VERDICT_NOT_READY: begin
            key = SK_NOT_READY; code = SC_NOT_READY;
         end
         default: begin
            key = SK_ILLEGAL; code = SC_BAD_FIELD;
         end
      endcase
      tlba = s2_ext_ff ? s2_lba_ff : {24'h0, s2_lba_ff[23:0]};

      rsp_tdata_in        = '0;
      rsp_tdata_in[0]     = ok;
      rsp_tdata_in[2:1]   = key;
      rsp_tdata_in[5:3]   = code;
      if (ok) begin
         rsp_tdata_in[13:6]  = s2_cmd_ff;
         rsp_tdata_in[21:14] = tdev_ff;
         rsp_tdata_in[29:22] = s2_count_ff;
         rsp_tdata_in[77:30] = tlba;
         rsp_tdata_in[78]    = s2_ext_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

### test/ata_passthrough_policy_check_top_tb.sv
// Self-checking testbench for the ATA pass-through policy check top level.
// Drives CDB beats with random gaps and response stalls, predicts every answer
// in place, and compares it field by field. Depends on appc_pkg and the RTL.
module ata_passthrough_policy_check_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import appc_pkg::*;

   localparam int SECTOR_BYTES = SECTOR_BYTES_DEF;
   localparam int PIPE_DEPTH   = 3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BEATS  = 146;

   // One request beat, fields as they sit in req_tdata
   typedef struct packed {
      logic [31:0] xfer;
      logic        data_in;
      logic [7:0]  length;
      logic [63:0] tail;
      logic [63:0] head;
   } cdb_req_t;

   // One answer, laid out exactly like rsp_tdata[78:0]
   typedef struct packed {
      logic        extended;
      logic [47:0] task_lba;
      logic [7:0]  sector_count;
      logic [7:0]  ata_device;
      logic [7:0]  ata_command;
      logic [2:0]  sense_code;
      logic [1:0]  sense_key;
      logic        allowed;
   } task_file_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the configuration registers
   logic [7:0] cfg_max_sectors = MAX_SECTORS_RST;
   logic       cfg_mounted = 1'b0;
   logic       cfg_lba_mode = 1'b0;

   task_file_t answers_q[$];
   int         mismatches = 0;
   int         answer_count = 0;
   bit         steady_flow = 1'b0;

   ata_passthrough_policy_check_top #(
      .SECTOR_BYTES(SECTOR_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic task_file_t refusal(input logic [1:0] key, input logic [2:0] code);
      task_file_t tf;
      tf = '0;
      tf.sense_key = key;
      tf.sense_code = code;
      return tf;
   endfunction

   function automatic task_file_t judge_cdb(input cdb_req_t r);
      task_file_t tf;
      logic [7:0] c [16];
      logic [7:0] b1, feat, hfeat, count, hcount, dev, cmd, ctrl, tdev;
      logic [7:0] l0, l1, l2, l3, l4, l5;
      logic       is16, ext;
      logic [63:0] lba;
      int k;
      for (k = 0; k < 8; k++) begin
         c[k] = r.head[8*k +: 8];
         c[k+8] = r.tail[8*k +: 8];
      end
      // form: opcode must agree with declared length
      if (c[0] == OPC_SAT12 && r.length == LEN_SAT12) begin
         is16 = 1'b0;
      end else if (c[0] == OPC_SAT16 && r.length == LEN_SAT16) begin
         is16 = 1'b1;
      end else begin
         return refusal(SK_ILLEGAL, SC_BAD_OPCODE);
      end
      b1 = c[1];
      hfeat = '0; hcount = '0; l3 = '0; l4 = '0; l5 = '0; ext = 1'b0;
      if (!is16) begin
         feat = c[3]; count = c[4];
         l0 = c[5]; l1 = c[6]; l2 = c[7];
         dev = c[8]; cmd = c[9]; ctrl = c[11];
         if (b1[0] || c[10] != 8'h00) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
      end else begin
         ext = b1[0];
         hfeat = c[3]; feat = c[4];
         hcount = c[5]; count = c[6];
         l3 = c[7]; l0 = c[8];
         l4 = c[9]; l1 = c[10];
         l5 = c[11]; l2 = c[12];
         dev = c[13]; cmd = c[14]; ctrl = c[15];
      end
      // protocol, byte 2, control, features, device bit 4
      if (b1[7:5] != 3'b000 || b1[4:1] != PROTO_PIO_IN)
         return refusal(SK_ILLEGAL, SC_BAD_FIELD);
      if (c[2] != BYTE2_PIO_IN || ctrl != 0 || feat != 0 || hfeat != 0)
         return refusal(SK_ILLEGAL, SC_BAD_FIELD);
      if (dev[4]) return refusal(SK_ILLEGAL, SC_BAD_FIELD);

      // command list with count and range checks
      case (cmd)
         CMD_IDENTIFY: begin
            if (ext || count != 8'd1 || hcount != 0) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            if ((l0 | l1 | l2 | l3 | l4 | l5) != 0) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            if (dev[3:0] != 4'h0) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            tdev = 8'h00;
         end
         CMD_READ, CMD_READ_NR: begin
            if (ext || (hcount | l3 | l4 | l5) != 0) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            if (!dev[6]) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            if (count == 0 || count > cfg_max_sectors)
               return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            lba = {36'b0, dev[3:0], l2, l1, l0};
            if (lba + 64'(count) > (64'd1 << 28)) return refusal(SK_ILLEGAL, SC_LBA_RANGE);
            tdev = DEV_LBA | {4'h0, dev[3:0]};
         end
         CMD_READ_EXT: begin
            if (!is16 || !ext || hcount != 0) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            if ((dev & DEV_EXT_MASK) != DEV_LBA) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            if (count == 0 || count > cfg_max_sectors)
               return refusal(SK_ILLEGAL, SC_BAD_FIELD);
            lba = {16'b0, l5, l4, l3, l2, l1, l0};
            if (lba + 64'(count) > (64'd1 << 48)) return refusal(SK_ILLEGAL, SC_LBA_RANGE);
            tdev = DEV_LBA;
         end
         default: return refusal(SK_ILLEGAL, SC_BAD_FIELD);
      endcase

      // direction and transfer length
      if (!r.data_in) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
      if (r.xfer != 32'(count) * 32'(SECTOR_BYTES)) return refusal(SK_ILLEGAL, SC_BAD_FIELD);
      // mount, then LBA mode for reads
      if (!cfg_mounted) return refusal(SK_NOT_READY, SC_NOT_READY);
      if (cmd != CMD_IDENTIFY && !cfg_lba_mode) return refusal(SK_ILLEGAL, SC_BAD_FIELD);

      tf = '0;
      tf.allowed = 1'b1;
      tf.sense_key = SK_NONE;
      tf.sense_code = SC_NONE;
      tf.ata_command = cmd;
      tf.ata_device = tdev;
      tf.sector_count = count;
      tf.task_lba = {24'b0, l2, l1, l0};
      if (ext) tf.task_lba[47:24] = {l5, l4, l3};
      tf.extended = ext;
      return tf;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Well-formed PIO-in CDB; 12-byte form takes lba[23:0], high nibble in dev
   function automatic cdb_req_t build_cdb(input bit is16, input bit ext, input logic [7:0] cmd,
                                          input logic [7:0] count, input logic [47:0] lba,
                                          input logic [7:0] dev);
      cdb_req_t r;
      logic [7:0] c [16];
      int k;
      for (k = 0; k < 16; k++) c[k] = 8'h00;
      c[1] = {3'b000, PROTO_PIO_IN, ext};
      c[2] = BYTE2_PIO_IN;
      if (!is16) begin
         c[0] = OPC_SAT12; c[4] = count;
         c[5] = lba[7:0]; c[6] = lba[15:8]; c[7] = lba[23:16];
         c[8] = dev; c[9] = cmd;
      end else begin
         c[0] = OPC_SAT16; c[6] = count;
         c[7] = lba[31:24]; c[8] = lba[7:0]; c[9] = lba[39:32];
         c[10] = lba[15:8]; c[11] = lba[47:40]; c[12] = lba[23:16];
         c[13] = dev; c[14] = cmd;
      end
      for (k = 0; k < 8; k++) begin
         r.head[8*k +: 8] = c[k];
         r.tail[8*k +: 8] = c[k+8];
      end
      // bytes 12..15 carry nothing in the short form
      if (!is16) r.tail[63:32] = $urandom;
      r.length = is16 ? LEN_SAT16 : LEN_SAT12;
      r.data_in = 1'b1;
      r.xfer = 32'(count) * 32'(SECTOR_BYTES);
      return r;
   endfunction

   // Gap length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int p;
      if (steady_flow) return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic cdb_req_t random_cdb();
      cdb_req_t r;
      int pick;
      bit is16;
      logic [7:0] cmd, count, dev, top;
      logic [27:0] lba28;
      logic [47:0] lba48;
      pick = $urandom_range(0, 99);
      is16 = $urandom_range(0, 1);
      top = (cfg_max_sectors == 0) ? 8'd255 : cfg_max_sectors;
      count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, top));
      dev = 8'($urandom) & 8'hA0;   // bits 7 and 5 are don't-care
      if (pick < 10) begin
         // noise; half of it with a matching opcode and length
         r.head = {$urandom, $urandom};
         r.tail = {$urandom, $urandom};
         r.length = 8'($urandom);
         r.data_in = $urandom_range(0, 1);
         r.xfer = $urandom;
         if (pick < 5) begin
            r.head[7:0] = is16 ? OPC_SAT16 : OPC_SAT12;
            r.length = is16 ? LEN_SAT16 : LEN_SAT12;
         end
         return r;
      end else if (pick < 25) begin
         r = build_cdb(is16, 1'b0, CMD_IDENTIFY, 8'd1, 48'h0, 8'($urandom) & 8'hE0);
      end else if (pick < 60) begin
         cmd = $urandom_range(0, 1) ? CMD_READ : CMD_READ_NR;
         lba28 = 28'($urandom);
         if ($urandom_range(0, 5) == 0)
            lba28 = 28'hFFF_FFFF - 28'(count) + 28'($urandom_range(0, 2));
         r = build_cdb(is16, 1'b0, cmd, count, {24'b0, lba28[23:0]},
                       dev | DEV_LBA | {4'h0, lba28[27:24]});
      end else begin
         lba48 = {16'($urandom), $urandom};
         if ($urandom_range(0, 5) == 0)
            lba48 = 48'hFFFF_FFFF_FFFF - 48'(count) + 48'($urandom_range(0, 2));
         r = build_cdb(1'b1, 1'b1, CMD_READ_EXT, count, lba48, dev | DEV_LBA);
      end
      // break about a quarter of the well-formed commands in one place
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 4))
            0: r.head[$urandom_range(8, 63)] = ~r.head[$urandom_range(8, 63)];
            1: r.tail[$urandom_range(0, 63)] = ~r.tail[$urandom_range(0, 63)];
            2: r.data_in = ~r.data_in;
            3: r.xfer = r.xfer ^ (32'd1 << $urandom_range(0, 31));
            default: r.length = r.length ^ (8'd1 << $urandom_range(0, 7));
         endcase
      end
      return r;
   endfunction

   // Send one beat after a random gap; valid stays up for a back-to-back beat
   task automatic send_cdb(input cdb_req_t r);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {{(REQ_W-$bits(cdb_req_t)){1'b0}}, r};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      answers_q.push_back(judge_cdb(r));
   endtask

   // Stop sending and let every outstanding answer come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (answers_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MAX_SECTORS:   cfg_max_sectors = data;
         CSR_DRIVE_MOUNTED: cfg_mounted = data[0];
         CSR_LBA_MODE:      cfg_lba_mode = data[0];
         default: ;
      endcase
   endtask

   // Write all three registers while idle; upper bits of the flags are junk
   task automatic set_config(input logic [7:0] max_sec, input logic mounted, input logic lba_on);
      wait_idle();
      csr_write(CSR_MAX_SECTORS, max_sec);
      csr_write(CSR_DRIVE_MOUNTED, {7'($urandom), mounted});
      csr_write(CSR_LBA_MODE, {7'($urandom), lba_on});
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls
   // ------------------------------------------------------------------
   initial begin
      forever begin
         if (steady_flow) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 65);
            repeat (1 + idle_cycles()) @(posedge clock);
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 60)
         $display("mismatch on answer %0d: %s got %h want %h", answer_count, what, got, want);
   endtask

   // Compare each answer beat with the oldest prediction
   always @(posedge clock) begin : answer_check
      task_file_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(task_file_t)-1:0];
         if (answers_q.size() == 0) begin
            report_mismatch("unexpected beat", 64'(got), 64'h0);
         end else begin
            want = answers_q.pop_front();
            if (got.allowed !== want.allowed)
               report_mismatch("allowed", 64'(got.allowed), 64'(want.allowed));
            if (got.sense_key !== want.sense_key)
               report_mismatch("sense_key", 64'(got.sense_key), 64'(want.sense_key));
            if (got.sense_code !== want.sense_code)
               report_mismatch("sense_code", 64'(got.sense_code), 64'(want.sense_code));
            if (got.ata_command !== want.ata_command)
               report_mismatch("ata_command", 64'(got.ata_command), 64'(want.ata_command));
            if (got.ata_device !== want.ata_device)
               report_mismatch("ata_device", 64'(got.ata_device), 64'(want.ata_device));
            if (got.sector_count !== want.sector_count)
               report_mismatch("sector_count", 64'(got.sector_count), 64'(want.sector_count));
            if (got.task_lba !== want.task_lba)
               report_mismatch("task_lba", 64'(got.task_lba), 64'(want.task_lba));
            if (got.extended !== want.extended)
               report_mismatch("extended", 64'(got.extended), 64'(want.extended));
         end
         answer_count++;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Registers at reset: unmounted, so good commands are not ready
   task automatic test_reset_defaults();
      send_cdb(build_cdb(1'b0, 1'b0, CMD_IDENTIFY, 8'd1, 48'h0, 8'h00));
      send_cdb(build_cdb(1'b1, 1'b1, CMD_READ_EXT, 8'd8, 48'h1234, DEV_LBA));
      send_cdb('0);
   endtask

   task automatic test_form_and_fields();
      cdb_req_t r;
      set_config(8'd255, 1'b1, 1'b1);
      send_cdb(build_cdb(1'b1, 1'b0, CMD_IDENTIFY, 8'd1, 48'h0, 8'hE0));
      send_cdb(build_cdb(1'b0, 1'b0, CMD_READ, 8'd255, 48'hBCDEF0, 8'h4A));
      // 28-bit range edge: last sector fits, one more does not
      send_cdb(build_cdb(1'b1, 1'b0, CMD_READ_NR, 8'd1, 48'hFF_FFFF, 8'h4F));
      send_cdb(build_cdb(1'b1, 1'b0, CMD_READ_NR, 8'd2, 48'hFF_FFFF, 8'h4F));
      // 48-bit range edge
      send_cdb(build_cdb(1'b1, 1'b1, CMD_READ_EXT, 8'd16, 48'hFFFF_FFFF_FFF0, 8'hE0));
      send_cdb(build_cdb(1'b1, 1'b1, CMD_READ_EXT, 8'd16, 48'hFFFF_FFFF_FFF1, 8'h40));
      // short form ignores bytes 12..15
      r = build_cdb(1'b0, 1'b0, CMD_READ, 8'd4, 48'h000100, 8'h40);
      r.tail[63:32] = 32'hFFFF_FFFF;
      send_cdb(r);
      // opcode and length disagree
      r.length = LEN_SAT16;
      send_cdb(r);
      r = build_cdb(1'b1, 1'b0, CMD_IDENTIFY, 8'd1, 48'h0, 8'h00);
      r.length = LEN_SAT12;
      send_cdb(r);
      // direction and transfer length
      r = build_cdb(1'b1, 1'b0, CMD_READ, 8'd3, 48'h10, 8'h40);
      r.data_in = 1'b0;
      send_cdb(r);
      r.data_in = 1'b1;
      r.xfer = r.xfer + 32'd1;
      send_cdb(r);
      // protocol, byte 2, control and device bit 4
      r = build_cdb(1'b1, 1'b0, CMD_READ, 8'd3, 48'h10, 8'h40);
      r.head[15:8] = {3'b000, 4'd5, 1'b0};
      send_cdb(r);
      r = build_cdb(1'b1, 1'b0, CMD_READ, 8'd3, 48'h10, 8'h40);
      r.head[23:16] = 8'h0F;
      send_cdb(r);
      r = build_cdb(1'b1, 1'b0, CMD_READ, 8'd3, 48'h10, 8'h40);
      r.tail[63:56] = 8'h01;
      send_cdb(r);
      send_cdb(build_cdb(1'b1, 1'b0, CMD_READ, 8'd3, 48'h10, 8'h50));
      // zero count, extended command in short form, unknown command
      send_cdb(build_cdb(1'b1, 1'b0, CMD_READ, 8'd0, 48'h10, 8'h40));
      send_cdb(build_cdb(1'b0, 1'b0, CMD_READ_EXT, 8'd1, 48'h10, 8'h40));
      send_cdb(build_cdb(1'b1, 1'b0, 8'h25, 8'd1, 48'h10, 8'h40));
      // short form with byte 10 set
      r = build_cdb(1'b0, 1'b0, CMD_READ, 8'd1, 48'h10, 8'h40);
      r.tail[23:16] = 8'h01;
      send_cdb(r);
      // all ones with a valid opcode
      r.head = '1;
      r.tail = '1;
      r.head[7:0] = OPC_SAT16;
      r.length = LEN_SAT16;
      r.xfer = '1;
      send_cdb(r);
   endtask

   task automatic test_mount_and_lba_mode();
      set_config(8'd128, 1'b1, 1'b0);
      send_cdb(build_cdb(1'b0, 1'b0, CMD_READ, 8'd1, 48'h0, 8'h40));
      send_cdb(build_cdb(1'b0, 1'b0, CMD_IDENTIFY, 8'd1, 48'h0, 8'h00));
      // zero max_sectors refuses every read
      set_config(8'd0, 1'b1, 1'b1);
      send_cdb(build_cdb(1'b1, 1'b0, CMD_READ, 8'd1, 48'h0, 8'h40));
      send_cdb(build_cdb(1'b1, 1'b0, CMD_IDENTIFY, 8'd1, 48'h0, 8'h40));
      set_config(8'd1, 1'b1, 1'b1);
      send_cdb(build_cdb(1'b1, 1'b1, CMD_READ_EXT, 8'd1, 48'h8000_0000_0000, 8'h40));
      send_cdb(build_cdb(1'b1, 1'b1, CMD_READ_EXT, 8'd2, 48'h8000_0000_0000, 8'h40));
   endtask

   task automatic test_random_sweep();
      int phase, i;
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_config(8'd1, 1'b1, 1'b1);
            1: set_config(8'd255, 1'b1, 1'b1);
            2: set_config(8'($urandom_range(1, 255)), 1'b1, 1'b1);
            3: set_config(8'd0, 1'b1, 1'b1);
            4: set_config(8'($urandom_range(1, 255)), 1'b0, 1'($urandom_range(0, 1)));
            5: set_config(8'($urandom_range(1, 255)), 1'b1, 1'b0);
            default: set_config(8'($urandom_range(1, 255)), 1'b1, 1'b1);
         endcase
         // first phase runs with no gaps and no stalls
         steady_flow = (phase == 0);
         for (i = 0; i < PHASE_BEATS; i++) begin
            // mid-run, hold off until the pipeline has drained
            if (phase == 2 && i == PHASE_BEATS / 2) wait_idle();
            send_cdb(random_cdb());
         end
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_form_and_fields();
      test_mount_and_lba_mode();
      test_random_sweep();
      wait_idle();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
